[hw/rtl/npfs_pkg.sv]
package npfs_pkg;

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CURSOR_X   = 2'd0;
    localparam logic [1:0] CFG_CURSOR_Y   = 2'd1;
    localparam logic [1:0] CFG_MIN_RATING = 2'd2;

    localparam logic [11:0] CURSOR_X_RESET   = 12'd1088;
    localparam logic [11:0] CURSOR_Y_RESET   = 12'd1104;
    localparam logic [2:0]  MIN_RATING_RESET = 3'd0;

    // Map corners and size.
    localparam longint TOP_LAT_L    = 64'sd5361858;
    localparam longint BOTTOM_LAT_L = 64'sd5340953;
    localparam longint LEFT_LON_L   = -64'sd11368652;
    localparam longint RIGHT_LON_L  = -64'sd11333496;
    localparam longint MAP_SIZE_L   = 64'sd2048;

    localparam longint LON_SPAN = RIGHT_LON_L - LEFT_LON_L;
    localparam longint LAT_SPAN = TOP_LAT_L - BOTTOM_LAT_L;

    localparam logic signed [26:0] LEFT_LON = 27'(LEFT_LON_L);
    localparam logic signed [25:0] TOP_LAT  = 26'(TOP_LAT_L);

    // A map coordinate of 2**17 or more saturates the distance anyway, so the
    // offset magnitudes are clamped to the value that maps exactly to 2**17.
    localparam int          Q_W     = 18;
    localparam int          U_W     = 22;
    localparam logic [U_W-1:0] X_CLAMP = U_W'(((64'sd1 << 17) * LON_SPAN) / MAP_SIZE_L);
    localparam logic [U_W-1:0] Y_CLAMP = U_W'(((64'sd1 << 17) * LAT_SPAN) / MAP_SIZE_L);

    // floor(u * 2048 / span) = (u * ceil(2**49 / span)) >> 38, exact for u < 2**22.
    localparam int RECIP_SHIFT = 38;
    localparam int RECIP_W     = 35;
    localparam int PROD_W      = U_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_X =
        RECIP_W'(((MAP_SIZE_L << RECIP_SHIFT) + LON_SPAN - 64'sd1) / LON_SPAN);
    localparam logic [RECIP_W-1:0] RECIP_Y =
        RECIP_W'(((MAP_SIZE_L << RECIP_SHIFT) + LAT_SPAN - 64'sd1) / LAT_SPAN);

    // Stored entry: ordered by distance, then by arrival number.
    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] idx;
    } t_key;

    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
        t_key key;
    } t_chain_ctl;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        pass;
        logic [15:0] distance;
    } t_item;

endpackage

[hw/rtl/npfs_in_if.sv]
interface npfs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [24:0] latitude;
    logic signed [25:0] longitude;
    logic [7:0]         record_rating;

    modport source (output valid, cmd, latitude, longitude, record_rating, input ready);
    modport sink   (input valid, cmd, latitude, longitude, record_rating, output ready);
endinterface

[hw/rtl/npfs_out_if.sv]
interface npfs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] record_index;
    logic [15:0] distance;
    logic        found;
    logic [11:0] remaining;
    logic        overflow;

    modport source (output valid, record_index, distance, found, remaining, overflow,
                    input ready);
    modport sink   (input valid, record_index, distance, found, remaining, overflow,
                    output ready);
endinterface

[hw/rtl/npfs_dist_pipe.sv]
module npfs_dist_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [24:0] i_lat,
    input  logic signed [25:0] i_lon,
    input  logic [7:0]         i_rating,
    input  logic [11:0]        i_cursor_x,
    input  logic [11:0]        i_cursor_y,
    input  logic [2:0]         i_min_rating,
    output logic               o_valid,
    output npfs_pkg::t_item    o_item,
    input  logic               i_ready
);
    import npfs_pkg::*;

    logic en1, en2, en3;

    // Stage 1: offsets from the map corner, magnitudes and rating test.
    logic signed [26:0] dlon;
    logic signed [25:0] dlat;
    logic [26:0]        lon_mag;
    logic [25:0]        lat_mag;
    logic [8:0]         rating_inc;

    logic              r_v1, r_pass1, r_xneg1, r_yneg1;
    logic [1:0]        r_cmd1;
    logic [U_W-1:0]    r_ux, r_uy;

    // Stage 2: map coordinates.
    logic [PROD_W-1:0] prod_x, prod_y;
    logic              r_v2, r_pass2, r_xneg2, r_yneg2;
    logic [1:0]        r_cmd2;
    logic [Q_W-1:0]    r_qx, r_qy;

    // Stage 3: Manhattan distance.
    logic signed [19:0] x_s, y_s, dx, dy;
    logic [19:0]        adx, ady;
    logic [20:0]        dsum;
    logic               r_v3;
    t_item              r_item3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    assign dlon       = $signed({i_lon[25], i_lon}) - LEFT_LON;
    assign dlat       = $signed({i_lat[24], i_lat}) - TOP_LAT;
    assign lon_mag    = dlon[26] ? 27'(-dlon) : 27'(dlon);
    assign lat_mag    = dlat[25] ? 26'(-dlat) : 26'(dlat);
    assign rating_inc = {1'b0, i_rating} + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cmd1  <= i_cmd;
            r_pass1 <= rating_inc[8:1] >= {5'd0, i_min_rating};
            r_ux    <= (lon_mag >= 27'(X_CLAMP)) ? X_CLAMP : lon_mag[U_W-1:0];
            r_uy    <= (lat_mag >= 26'(Y_CLAMP)) ? Y_CLAMP : lat_mag[U_W-1:0];
            r_xneg1 <= dlon[26];
            // The latitude axis runs from north to south, so y flips sign.
            r_yneg1 <= !dlat[25];
        end
    end

    assign prod_x = PROD_W'(r_ux) * PROD_W'(RECIP_X);
    assign prod_y = PROD_W'(r_uy) * PROD_W'(RECIP_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_cmd2  <= r_cmd1;
            r_pass2 <= r_pass1;
            r_qx    <= prod_x[RECIP_SHIFT +: Q_W];
            r_qy    <= prod_y[RECIP_SHIFT +: Q_W];
            r_xneg2 <= r_xneg1;
            r_yneg2 <= r_yneg1;
        end
    end

    assign x_s  = r_xneg2 ? -$signed({2'd0, r_qx}) : $signed({2'd0, r_qx});
    assign y_s  = r_yneg2 ? -$signed({2'd0, r_qy}) : $signed({2'd0, r_qy});
    assign dx   = $signed({8'd0, i_cursor_x}) - x_s;
    assign dy   = $signed({8'd0, i_cursor_y}) - y_s;
    assign adx  = dx[19] ? 20'(-dx) : 20'(dx);
    assign ady  = dy[19] ? 20'(-dy) : 20'(dy);
    assign dsum = {1'b0, adx} + {1'b0, ady};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_item3.cmd      <= r_cmd2;
            r_item3.pass     <= r_pass2;
            r_item3.distance <= (dsum > 21'd65535) ? 16'hFFFF : dsum[15:0];
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;

endmodule

[hw/rtl/npfs_cell.sv]
module npfs_cell #(
    parameter int CNT_W = 12,
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  npfs_pkg::t_chain_ctl i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  npfs_pkg::t_key       i_prev_key,
    input  logic                 i_prev_gt,
    input  npfs_pkg::t_key       i_next_key,
    output npfs_pkg::t_key       o_key,
    output logic                 o_gt
);
    import npfs_pkg::*;

    t_key r_key;
    t_key n_key;
    logic occupied;

    assign occupied = i_count > CNT_W'(INDEX);
    // An empty cell counts as holding a key above every real one.
    assign o_gt     = !occupied || (r_key > i_ctl.key);

    always_comb begin
        n_key = r_key;
        if (i_ctl.insert) begin
            if (o_gt) begin
                n_key = i_prev_gt ? i_prev_key : i_ctl.key;
            end
        end else if (i_ctl.pop) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

[hw/rtl/npfs_chain.sv]
module npfs_chain #(
    parameter int STORE_DEPTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  npfs_pkg::t_chain_ctl           i_ctl,
    output logic [$clog2(STORE_DEPTH+1)-1:0] o_count,
    output npfs_pkg::t_key                 o_head
);
    import npfs_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    t_key             keys [STORE_DEPTH];
    logic             gts  [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.insert) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Each cell looks only at its left neighbor on an insert and at its right
    // neighbor on a pop, so every cell of the row shifts in the same cycle.
    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
        t_key prev_key, next_key;
        logic prev_gt;

        if (i == 0) begin : g_first
            assign prev_key = i_ctl.key;
            assign prev_gt  = 1'b0;
        end else begin : g_inner
            assign prev_key = keys[i-1];
            assign prev_gt  = gts[i-1];
        end

        if (i == STORE_DEPTH - 1) begin : g_last
            assign next_key = i_ctl.key;
        end else begin : g_body
            assign next_key = keys[i+1];
        end

        npfs_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_count    (r_count),
            .i_prev_key (prev_key),
            .i_prev_gt  (prev_gt),
            .i_next_key (next_key),
            .o_key      (keys[i]),
            .o_gt       (gts[i])
        );
    end

    assign o_count = r_count;
    assign o_head  = keys[0];

endmodule

[hw/rtl/nearest_point_filter_sort_core.sv]
// Channel  | Direction | Beat contents
// i_in     | in        | cmd, latitude, longitude, record_rating
// o_out    | out       | record_index, distance, found, remaining, overflow (pop only)
// i_cfg_*  | in        | write enable, register index, 12-bit data
//
// One beat is accepted per cycle while the input is not stalled. A command
// passes the corner offset, reciprocal multiply and distance stages and then
// takes effect on the sorted chain; a pop result enters the output register as
// the pop shifts the chain. A kept load or a pop shifts the whole cell row.
// Input stalls only while a pop waits at the chain for the output register.
// Reset is synchronous; no clearing pass is needed.
module nearest_point_filter_sort_core #(
    parameter int STORE_DEPTH = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    npfs_in_if.sink           i_in,
    npfs_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [11:0]       i_cfg_data
);
    import npfs_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic [11:0] r_cursor_x, r_cursor_y;
    logic [2:0]  r_min_rating;
    logic [16:0] r_rec_cnt;
    logic        r_dropped;

    logic        pipe_valid, pipe_take, commit;
    t_item       pipe_item;
    t_chain_ctl  ctl;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_less;
    t_key        head;
    logic        is_load, is_pop, is_clear, full, keep, not_empty;

    logic        r_out_valid, r_found, r_overflow;
    logic [15:0] r_out_idx, r_out_dist;
    logic [11:0] r_remaining;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x   <= CURSOR_X_RESET;
            r_cursor_y   <= CURSOR_Y_RESET;
            r_min_rating <= MIN_RATING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CURSOR_X:   r_cursor_x   <= i_cfg_data;
                CFG_CURSOR_Y:   r_cursor_y   <= i_cfg_data;
                CFG_MIN_RATING: r_min_rating <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    npfs_dist_pipe u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_cmd        (i_in.cmd),
        .i_lat        (i_in.latitude),
        .i_lon        (i_in.longitude),
        .i_rating     (i_in.record_rating),
        .i_cursor_x   (r_cursor_x),
        .i_cursor_y   (r_cursor_y),
        .i_min_rating (r_min_rating),
        .o_valid      (pipe_valid),
        .o_item       (pipe_item),
        .i_ready      (pipe_take)
    );

    assign is_load   = pipe_item.cmd == CMD_LOAD;
    assign is_pop    = pipe_item.cmd == CMD_POP;
    assign is_clear  = pipe_item.cmd == CMD_CLEAR;
    assign pipe_take = !is_pop || !r_out_valid || o_out.ready;
    assign commit    = pipe_valid && pipe_take;

    assign full       = count == CNT_W'(STORE_DEPTH);
    assign not_empty  = count != '0;
    assign count_less = count - CNT_W'(1);
    // Record numbers above 65535 cannot be stored, nor can anything once full.
    assign keep      = commit && is_load && pipe_item.pass;

    always_comb begin
        ctl.insert       = keep && !r_rec_cnt[16] && !full;
        ctl.pop          = commit && is_pop && not_empty;
        ctl.clear        = commit && is_clear;
        ctl.key.distance = pipe_item.distance;
        ctl.key.idx      = r_rec_cnt[15:0];
    end

    npfs_chain #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_count (count),
        .o_head  (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_cnt <= '0;
            r_dropped <= 1'b0;
        end else if (commit) begin
            if (is_clear) begin
                r_rec_cnt <= '0;
                r_dropped <= 1'b0;
            end else if (is_load) begin
                if (!r_rec_cnt[16]) begin
                    r_rec_cnt <= r_rec_cnt + 17'd1;
                end
                if (keep && (r_rec_cnt[16] || full)) begin
                    r_dropped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit && is_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && is_pop) begin
            r_found     <= not_empty;
            r_out_idx   <= not_empty ? head.idx : 16'd0;
            r_out_dist  <= not_empty ? head.distance : 16'd0;
            r_remaining <= not_empty ? 12'(count_less) : 12'd0;
            r_overflow  <= r_dropped;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.record_index = r_out_idx;
    assign o_out.distance     = r_out_dist;
    assign o_out.found        = r_found;
    assign o_out.remaining    = r_remaining;
    assign o_out.overflow     = r_overflow;

endmodule
